// ===== sv/ikq_pkg.sv =====
// Shared types and constants for the input event key queue.
package ikq_pkg;

   typedef enum logic [1:0] {
      OP_EVENT = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_QUERY = 2'd3
   } ikq_op_type;

   localparam logic [4:0] EV_SYNC = 5'd0;
   localparam logic [4:0] EV_KEY  = 5'd1;
   localparam logic [4:0] EV_REL  = 5'd2;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_AXIS      = 2'd1;
   localparam logic [1:0] CSR_DOWN_KEY  = 2'd2;
   localparam logic [1:0] CSR_UP_KEY    = 2'd3;

   localparam logic [6:0]  THRESHOLD_RESET = 7'd3;
   localparam logic [15:0] AXIS_RESET      = 16'd1;
   localparam logic [9:0]  DOWN_KEY_RESET  = 10'd108;
   localparam logic [9:0]  UP_KEY_RESET    = 10'd103;

   localparam logic [1:0] KEY_RELEASED = 2'd0;
   localparam logic [1:0] KEY_HELD     = 2'd1;
   localparam logic [1:0] KEY_REPEAT   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } ikq_state_type;

   typedef struct packed {
      ikq_op_type         operation;
      logic [4:0]         event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } ikq_req_type;

   typedef struct packed {
      logic [9:0] popped_key;
      logic       popped_valid;
      logic [1:0] pressed_value;
      logic [8:0] queue_count;
      logic       key_enqueued;
      logic       key_dropped;
   } ikq_rsp_type;

endpackage

// ===== sv/ikq_table.sv =====
// Pressed-state memory with a clearing sweep after reset.
module ikq_table #(
   parameter int KEY_TABLE_SIZE = 768
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [$clog2(KEY_TABLE_SIZE)-1:0] rd_addr,
   output logic [1:0]                        rd_data,
   input  logic                              wr_en,
   input  logic [$clog2(KEY_TABLE_SIZE)-1:0] wr_addr,
   input  logic [1:0]                        wr_data,
   output logic                              ready
);
   import ikq_pkg::*;

   localparam int TBL_W = $clog2(KEY_TABLE_SIZE);
   localparam logic [TBL_W-1:0] LAST = TBL_W'(KEY_TABLE_SIZE - 1);

   logic [1:0]       mem [KEY_TABLE_SIZE];
   logic             clearing_ff;
   logic [TBL_W-1:0] sweep_ff;
   logic [1:0]       rd_data_ff;

   logic             we;
   logic [TBL_W-1:0] waddr;
   logic [1:0]       wdata;

   always_comb begin
      if (clearing_ff) begin
         we    = 1'b1;
         waddr = sweep_ff;
         wdata = KEY_RELEASED;
      end else begin
         we    = wr_en;
         waddr = wr_addr;
         wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         sweep_ff    <= '0;
      end else if (clearing_ff) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (sweep_ff == LAST) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule

// ===== sv/input_event_key_queue.sv =====
// Input event key queue: motion-to-key synthesis, key FIFO and pressed-state table.
//
// An item is taken when start is high and busy is low. In the accept cycle
// the key FIFO and the pressed-state memory are read; in the next cycle (busy
// high) the item is evaluated and both memories and the queue pointers are
// written back. The result word is strobed on rsp_strobe for one cycle right
// after that; the receiver cannot stall, so it must take the word in that
// cycle. A new item may be started while a result is on the rsp ports, but not
// while the previous item is being evaluated. After reset the block stays busy
// while the pressed-state memory is swept to zero; register writes are taken
// during that time.
module input_event_key_queue #(
   parameter int QUEUE_DEPTH    = 256,
   parameter int KEY_TABLE_SIZE = 768
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ikq_pkg::ikq_req_type req_word,
   output logic                rsp_strobe,
   output ikq_pkg::ikq_rsp_type rsp_word,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import ikq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TBL_W = $clog2(KEY_TABLE_SIZE);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [15:0]      TBL_LIMIT = 16'(KEY_TABLE_SIZE);

   // configuration
   logic [6:0]  threshold_ff;
   logic [15:0] axis_ff;
   logic [9:0]  down_key_ff;
   logic [9:0]  up_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         axis_ff      <= AXIS_RESET;
         down_key_ff  <= DOWN_KEY_RESET;
         up_key_ff    <= UP_KEY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[6:0];
            CSR_AXIS:      axis_ff      <= csr_wdata;
            CSR_DOWN_KEY:  down_key_ff  <= csr_wdata[9:0];
            CSR_UP_KEY:    up_key_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // control and state
   ikq_state_type     state_ff, state_in;
   ikq_req_type       item_ff;
   logic signed [7:0] sum_ff, sum_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              strobe_ff, strobe_in;
   ikq_rsp_type       rsp_ff, rsp_in;

   logic accept;
   logic tbl_ready;
   logic exec;

   // key FIFO memory
   logic [9:0] fifo_mem [QUEUE_DEPTH];
   logic [9:0] fifo_rd_ff;
   logic       fifo_we;
   logic [9:0] fifo_wdata;

   // pressed table port
   logic [1:0]       tbl_rd_data;
   logic             tbl_we;
   logic [TBL_W-1:0] tbl_waddr;
   logic [1:0]       tbl_wdata;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign exec   = (state_ff == ST_EXEC);

   ikq_table #(
      .KEY_TABLE_SIZE(KEY_TABLE_SIZE)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_addr(req_word.event_code[TBL_W-1:0]),
      .rd_data(tbl_rd_data),
      .wr_en  (tbl_we),
      .wr_addr(tbl_waddr),
      .wr_data(tbl_wdata),
      .ready  (tbl_ready)
   );

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[wptr_ff] <= fifo_wdata;
      end
      if (accept) begin
         fifo_rd_ff <= fifo_mem[rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         sum_ff    <= '0;
         rptr_ff   <= '0;
         wptr_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         rptr_ff   <= rptr_in;
         wptr_ff   <= wptr_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // state sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (tbl_ready) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // item evaluation
   logic signed [32:0] sum_full;
   logic signed [32:0] thr_pos;
   logic signed [32:0] thr_neg;
   logic               is_key;
   logic               synthetic;
   logic [15:0]        kcode;
   logic               key_in_range;
   logic               press;
   logic [1:0]         key_state;
   logic [CNT_W+8:0]   count_ext;

   always_comb begin
      sum_full = {{25{sum_ff[7]}}, sum_ff} + {item_ff.event_value[31], item_ff.event_value};
      thr_pos  = {26'd0, threshold_ff};
      thr_neg  = -thr_pos;

      if (item_ff.event_value <= 0) begin
         key_state = KEY_RELEASED;
      end else if (item_ff.event_value >= 2) begin
         key_state = KEY_REPEAT;
      end else begin
         key_state = KEY_HELD;
      end

      sum_in     = sum_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      count_in   = count_ff;
      strobe_in  = exec;
      rsp_in     = '0;
      is_key     = 1'b0;
      synthetic  = 1'b0;
      kcode      = item_ff.event_code;
      fifo_we    = 1'b0;
      fifo_wdata = kcode[9:0];
      tbl_we     = 1'b0;
      tbl_waddr  = kcode[TBL_W-1:0];
      tbl_wdata  = key_state;
      key_in_range = 1'b0;
      press      = 1'b0;

      if (exec) begin
         case (item_ff.operation)
            OP_EVENT: begin
               if (item_ff.event_type == EV_SYNC) begin
                  sum_in = sum_ff;
               end else if (item_ff.event_type == EV_REL) begin
                  if (item_ff.event_code == axis_ff) begin
                     if (sum_full > thr_pos) begin
                        is_key    = 1'b1;
                        synthetic = 1'b1;
                        kcode     = {6'd0, down_key_ff};
                        sum_in    = '0;
                     end else if (sum_full < thr_neg) begin
                        is_key    = 1'b1;
                        synthetic = 1'b1;
                        kcode     = {6'd0, up_key_ff};
                        sum_in    = '0;
                     end else begin
                        sum_in = sum_full[7:0];
                     end
                  end
               end else begin
                  sum_in = '0;
                  is_key = (item_ff.event_type == EV_KEY);
               end

               key_in_range = is_key && (kcode < TBL_LIMIT);
               press        = synthetic || (item_ff.event_value > 0);
               fifo_wdata   = kcode[9:0];
               tbl_waddr    = kcode[TBL_W-1:0];
               tbl_we       = key_in_range && !synthetic;

               if (key_in_range && press) begin
                  if (count_ff == CNT_FULL) begin
                     rsp_in.key_dropped = 1'b1;
                  end else begin
                     fifo_we = 1'b1;
                     wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                     rsp_in.key_enqueued = 1'b1;
                  end
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  rsp_in.popped_key   = fifo_rd_ff;
                  rsp_in.popped_valid = 1'b1;
                  rptr_in  = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               rptr_in  = '0;
               wptr_in  = '0;
               count_in = '0;
            end
            OP_QUERY: begin
               if (item_ff.event_code < TBL_LIMIT) begin
                  rsp_in.pressed_value = tbl_rd_data;
               end
            end
            default: ;
         endcase
      end

      count_ext          = {9'd0, count_in};
      rsp_in.queue_count = count_ext[8:0];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== bench/input_event_key_queue_tb.sv =====
// Self-checking testbench for the input event key queue: directed table, a queue fill, then random phases.
`timescale 1ns / 1ps

module input_event_key_queue_tb;
   import ikq_pkg::*;

   localparam int KEY_SLOTS   = 768;
   localparam int QUEUE_SLOTS = 256;
   localparam int FILL_ITEMS  = 258;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   ikq_req_type req_word;
   logic        rsp_strobe;
   ikq_rsp_type rsp_word;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   input_event_key_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block's registers and state
   logic [6:0]  cfg_thresh;
   logic [15:0] cfg_axis;
   logic [9:0]  cfg_down;
   logic [9:0]  cfg_up;
   int          acc_motion;
   logic [9:0]  kq_mem [QUEUE_SLOTS];
   int          kq_head;
   int          kq_tail;
   int          kq_level;
   logic [1:0]  key_state [KEY_SLOTS];

   ikq_rsp_type key_outcomes[$];
   int          mismatch_count = 0;
   int          idle_pct = 0;

   typedef struct {
      ikq_req_type req;
      bit          typed;
      ikq_rsp_type rsp;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic ikq_rsp_type word_of(int key, bit valid, int pressed, int level,
                                           bit enq, bit drop);
      ikq_rsp_type r;
      r.popped_key    = 10'(key);
      r.popped_valid  = valid;
      r.pressed_value = 2'(pressed);
      r.queue_count   = 9'(level);
      r.key_enqueued  = enq;
      r.key_dropped   = drop;
      return r;
   endfunction

   function automatic ikq_rsp_type evaluate_item(ikq_req_type w);
      ikq_rsp_type r;
      longint      sum;
      longint      kval;
      logic [15:0] kcode;
      bit          is_key;
      bit          synth;
      r      = '0;
      is_key = 1'b0;
      synth  = 1'b0;
      kcode  = '0;
      kval   = 0;
      case (w.operation)
         OP_EVENT: begin
            if (w.event_type == EV_REL) begin
               if (w.event_code == cfg_axis) begin
                  sum = longint'(acc_motion) + longint'(w.event_value);
                  if (sum > longint'(cfg_thresh)) begin
                     is_key = 1'b1; synth = 1'b1; kcode = 16'(cfg_down); kval = 1;
                     acc_motion = 0;
                  end else if (sum < -longint'(cfg_thresh)) begin
                     is_key = 1'b1; synth = 1'b1; kcode = 16'(cfg_up); kval = 1;
                     acc_motion = 0;
                  end else begin
                     acc_motion = int'(sum);
                  end
               end
            end else if (w.event_type != EV_SYNC) begin
               acc_motion = 0;
               if (w.event_type == EV_KEY) begin
                  is_key = 1'b1;
                  kcode  = w.event_code;
                  kval   = longint'(w.event_value);
               end
            end
            if (is_key && kcode < KEY_SLOTS) begin
               if (!synth)
                  key_state[kcode] = (kval <= 0) ? KEY_RELEASED :
                                     (kval >= 2) ? KEY_REPEAT : KEY_HELD;
               if (kval > 0) begin
                  if (kq_level >= QUEUE_SLOTS) begin
                     r.key_dropped = 1'b1;
                  end else begin
                     kq_mem[kq_tail] = kcode[9:0];
                     kq_tail = (kq_tail + 1) % QUEUE_SLOTS;
                     kq_level++;
                     r.key_enqueued = 1'b1;
                  end
               end
            end
         end
         OP_POP: begin
            if (kq_level > 0) begin
               r.popped_key   = kq_mem[kq_head];
               r.popped_valid = 1'b1;
               kq_head = (kq_head + 1) % QUEUE_SLOTS;
               kq_level--;
            end
         end
         OP_CLEAR: begin
            kq_level = 0;
            kq_head  = 0;
            kq_tail  = 0;
         end
         default: begin
            if (w.event_code < KEY_SLOTS)
               r.pressed_value = key_state[w.event_code];
         end
      endcase
      r.queue_count = 9'(kq_level);
      return r;
   endfunction

   function automatic ikq_req_type random_item();
      ikq_req_type w;
      int          pick;
      w.operation   = OP_EVENT;
      w.event_type  = 5'($urandom);
      w.event_code  = 16'($urandom);
      w.event_value = $urandom;
      pick = $urandom_range(99);
      if (pick < 12) begin
         w.operation = OP_POP;
      end else if (pick < 14) begin
         w.operation = OP_CLEAR;
      end else if (pick < 28) begin
         w.operation = OP_QUERY;
         if ($urandom_range(9) != 0) w.event_code = 16'($urandom_range(KEY_SLOTS - 1));
      end else begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            w.event_type = EV_KEY;
            if ($urandom_range(9) != 0) w.event_code = 16'($urandom_range(KEY_SLOTS - 1));
            case ($urandom_range(5))
               0: w.event_value = 0;
               1: w.event_value = 1;
               2: w.event_value = 2;
               3: w.event_value = $urandom;
               4: w.event_value = -int'($urandom_range(3, 1));
               default: w.event_value = $urandom_range(9, 3);
            endcase
         end else if (pick < 82) begin
            w.event_type = EV_REL;
            if ($urandom_range(7) != 0) w.event_code = cfg_axis;
            if ($urandom_range(11) != 0)
               w.event_value = int'($urandom_range(2 * cfg_thresh + 4)) - int'(cfg_thresh) - 2;
         end else if (pick < 90) begin
            w.event_type = EV_SYNC;
         end else begin
            w.event_type = 5'($urandom_range(31, 3));
         end
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d, want %0d at %0t ns", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic send_item(ikq_req_type w, bit typed, ikq_rsp_type fixed);
      ikq_rsp_type r;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      r = evaluate_item(w);
      key_outcomes.push_back(typed ? fixed : r);
   endtask

   // stop sending and let every pending word come back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (key_outcomes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_THRESHOLD: cfg_thresh = data[6:0];
         CSR_AXIS:      cfg_axis   = data;
         CSR_DOWN_KEY:  cfg_down   = data[9:0];
         default:       cfg_up     = data[9:0];
      endcase
   endtask

   task automatic set_config(int thr, int axis, int down, int up);
      write_reg(CSR_THRESHOLD, 16'(thr));
      write_reg(CSR_AXIS, 16'(axis));
      write_reg(CSR_DOWN_KEY, 16'(down));
      write_reg(CSR_UP_KEY, 16'(up));
   endtask

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) send_item(random_item(), 1'b0, '0);
   endtask

   task automatic add_row(ikq_op_type op, logic [4:0] ev, logic [15:0] code,
                          logic [31:0] val, bit typed, ikq_rsp_type fixed);
      dir_row_type row;
      row.req.operation   = op;
      row.req.event_type  = ev;
      row.req.event_code  = code;
      row.req.event_value = val;
      row.typed = typed;
      row.rsp   = fixed;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_check
      ikq_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (key_outcomes.size() == 0) begin
            report_mismatch("word with nothing pending", 32'(rsp_word.queue_count), 0);
         end else begin
            want = key_outcomes.pop_front();
            if (rsp_word.popped_key !== want.popped_key)
               report_mismatch("popped_key", 32'(rsp_word.popped_key), 32'(want.popped_key));
            if (rsp_word.popped_valid !== want.popped_valid)
               report_mismatch("popped_valid", 32'(rsp_word.popped_valid),
                               32'(want.popped_valid));
            if (rsp_word.pressed_value !== want.pressed_value)
               report_mismatch("pressed_value", 32'(rsp_word.pressed_value),
                               32'(want.pressed_value));
            if (rsp_word.queue_count !== want.queue_count)
               report_mismatch("queue_count", 32'(rsp_word.queue_count), 32'(want.queue_count));
            if (rsp_word.key_enqueued !== want.key_enqueued)
               report_mismatch("key_enqueued", 32'(rsp_word.key_enqueued),
                               32'(want.key_enqueued));
            if (rsp_word.key_dropped !== want.key_dropped)
               report_mismatch("key_dropped", 32'(rsp_word.key_dropped), 32'(want.key_dropped));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      ikq_req_type w;
      reset     = 1'b1;
      start     = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_thresh = THRESHOLD_RESET;
      cfg_axis   = AXIS_RESET;
      cfg_down   = DOWN_KEY_RESET;
      cfg_up     = UP_KEY_RESET;
      acc_motion = 0;
      kq_head    = 0;
      kq_tail    = 0;
      kq_level   = 0;
      foreach (kq_mem[i]) kq_mem[i] = '0;
      foreach (key_state[i]) key_state[i] = KEY_RELEASED;

      // directed words, reset register values
      add_row(OP_POP,   EV_SYNC, 16'd0,     32'd0, 1'b1, word_of(0, 0, 0, 0, 0, 0));
      add_row(OP_QUERY, EV_SYNC, 16'd767,   32'd0, 1'b1, word_of(0, 0, 0, 0, 0, 0));
      add_row(OP_QUERY, EV_SYNC, 16'hffff,  32'd0, 1'b1, word_of(0, 0, 0, 0, 0, 0));
      add_row(OP_EVENT, EV_SYNC, 16'd1,     32'd5, 1'b1, word_of(0, 0, 0, 0, 0, 0));
      add_row(OP_EVENT, EV_KEY,  16'd0,     32'd1, 1'b1, word_of(0, 0, 0, 1, 1, 0));
      add_row(OP_EVENT, EV_KEY,  16'd767,   32'd2, 1'b1, word_of(0, 0, 0, 2, 1, 0));
      add_row(OP_EVENT, EV_KEY,  16'd768,   32'd1, 1'b1, word_of(0, 0, 0, 2, 0, 0));
      add_row(OP_EVENT, EV_KEY,  16'hffff,  32'sh8000_0000, 1'b1, word_of(0, 0, 0, 2, 0, 0));
      add_row(OP_EVENT, EV_KEY,  16'd5,     32'sh7fff_ffff, 1'b1, word_of(0, 0, 0, 3, 1, 0));
      add_row(OP_EVENT, EV_KEY,  16'd6,     -32'sd1, 1'b1, word_of(0, 0, 0, 3, 0, 0));
      add_row(OP_EVENT, EV_KEY,  16'd5,     32'd0, 1'b1, word_of(0, 0, 0, 3, 0, 0));
      add_row(OP_QUERY, EV_SYNC, 16'd767,   32'd0, 1'b1, word_of(0, 0, 2, 3, 0, 0));
      add_row(OP_QUERY, EV_SYNC, 16'd0,     32'd0, 1'b1, word_of(0, 0, 1, 3, 0, 0));
      add_row(OP_QUERY, EV_SYNC, 16'd5,     32'd0, 1'b1, word_of(0, 0, 0, 3, 0, 0));
      add_row(OP_EVENT, EV_REL,  16'd1,     32'd3, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     32'd1, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     -32'sd4, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd2,     32'd100, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     32'd2, 1'b0, '0);
      add_row(OP_EVENT, 5'd31,   16'd0,     -32'sd1, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     32'd2, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     32'sh7fff_ffff, 1'b0, '0);
      add_row(OP_EVENT, EV_REL,  16'd1,     32'sh8000_0000, 1'b0, '0);
      add_row(OP_QUERY, EV_SYNC, 16'd108,   32'd0, 1'b0, '0);
      add_row(OP_POP,   5'd31,   16'hffff,  32'hffff_ffff, 1'b0, '0);
      add_row(OP_CLEAR, EV_SYNC, 16'd0,     32'd0, 1'b1, word_of(0, 0, 0, 0, 0, 0));
      add_row(OP_POP,   EV_SYNC, 16'd0,     32'd0, 1'b1, word_of(0, 0, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first word waits out the table sweep through busy
      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // push the queue past full so the last presses get dropped
      for (int n = 0; n < FILL_ITEMS; n++) begin
         w = random_item();
         w.operation = OP_EVENT;
         if ($urandom_range(7) == 0) begin
            w.event_type  = EV_REL;
            w.event_code  = cfg_axis;
            w.event_value = $urandom_range(1) ? int'(cfg_thresh) + 1 : -int'(cfg_thresh) - 1;
         end else begin
            w.event_type  = EV_KEY;
            w.event_code  = 16'($urandom_range(KEY_SLOTS - 1));
            w.event_value = $urandom_range(2, 1);
         end
         send_item(w, 1'b0, '0);
      end

      drain();
      set_config(0, 0, 0, 767);
      idle_pct = 79;
      random_phase(45);

      drain();
      set_config(127, 65535, 767, 0);
      idle_pct = 18;
      random_phase(45);

      drain();
      set_config($urandom_range(127), $urandom_range(65535), $urandom_range(767),
                 $urandom_range(767));
      idle_pct = 0;
      random_phase(25);
      drain();
      random_phase(20);

      drain();
      set_config(THRESHOLD_RESET, AXIS_RESET, DOWN_KEY_RESET, UP_KEY_RESET);
      idle_pct = 79;
      random_phase(50);

      drain();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ikq_pkg.sv
sv/ikq_table.sv
sv/input_event_key_queue.sv
bench/input_event_key_queue_tb.sv
